// File: src/bpfa_pkg.sv
`timescale 1ns / 1ps
// Package of the bitmap page-frame allocator: field widths, request modes,
// status codes, register indexes and the sequencer state type. No dependencies.
package bpfa_pkg;

   localparam int MODE_W    = 2;
   localparam int COUNT_W   = 13;
   localparam int IDX_W     = 12;
   localparam int ADDR_W    = 64;
   localparam int STATUS_W  = 2;
   localparam int BASE_W    = 48;
   localparam int SHIFT_W   = 5;
   localparam int CSR_IDX_W = 1;

   // Base addresses are rounded up to a 4 KiB boundary.
   localparam logic [BASE_W:0] BASE_ROUND = (BASE_W + 1)'(12'hfff);

   localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = SHIFT_W'(12);

   localparam logic [CSR_IDX_W-1:0] CSR_FREE_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SHIFT = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC     = 2'd0,
      MODE_MARK_USED = 2'd1,
      MODE_MARK_FREE = 2'd2,
      MODE_QUERY     = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_RUN     = 2'd1,
      STATUS_ZERO_COUNT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_START,
      ST_SCAN,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_PAGE_RD,
      ST_PAGE_OP,
      ST_RESP
   } state_type;

endpackage

// File: src/bpfa_ifs.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the bitmap page-frame allocator.
// Depends on bpfa_pkg for the field widths.
interface bpfa_req_if;
   logic                         valid;
   logic                         ready;
   logic [bpfa_pkg::MODE_W-1:0]  mode;
   logic [bpfa_pkg::COUNT_W-1:0] count;
   logic [bpfa_pkg::IDX_W-1:0]   page_index;

   modport source (output valid, output mode, output count, output page_index, input ready);
   modport sink   (input valid, input mode, input count, input page_index, output ready);
endinterface

interface bpfa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpfa_pkg::ADDR_W-1:0]   phys_address;
   logic [bpfa_pkg::IDX_W-1:0]    run_start;
   logic [bpfa_pkg::STATUS_W-1:0] status;
   logic                          page_free;

   modport source (output valid, output phys_address, output run_start, output status,
                   output page_free, input ready);
   modport sink   (input valid, input phys_address, input run_start, input status,
                   input page_free, output ready);
endinterface

// File: src/bitmap_page_frame_allocator_core.sv
`timescale 1ns / 1ps
// Bitmap page-frame allocator core: first-fit run search over a usage bitmap
// held in a single-port-read, single-port-write memory. Depends on bpfa_pkg
// and the channel interfaces in bpfa_ifs.sv.
//
// One request is handled at a time; ready is high only while the sequencer is
// idle, and a finished response waits in its own register, so the next request
// is taken while the previous response is still pending. After reset a
// clearing pass writes every bitmap word to zero before the first request is
// accepted; register writes are taken throughout. An allocate request scans
// the bitmap words in order, one word per cycle through the memory read port
// and at most NWORDS of them, then reads and writes back in turn each word
// that the run covers. A mark request does one read-modify-write of the word
// that holds the page and a query request one read of it, the word being
// addressed by the upper bits of the page index, so WORD_BITS must be a power
// of two. A zero count, a count above the number of pages or a page index
// beyond the map goes straight to the response state without touching the
// bitmap. A response still held in the output register adds its waiting time
// to the next request.
module bitmap_page_frame_allocator_core #(
   parameter int NUM_PAGES = 4096,
   parameter int WORD_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   bpfa_req_if.sink                         req_if,
   bpfa_rsp_if.source                       rsp_if,
   input  logic                             csr_we,
   input  logic [bpfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpfa_pkg::BASE_W-1:0]      csr_wdata
);
   import bpfa_pkg::*;

   localparam int NWORDS    = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int PAGE_W    = $clog2(NUM_PAGES);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int LEN_W     = $clog2(WORD_BITS + 1);
   localparam int STEPS     = $clog2(WORD_BITS);
   localparam int LAST_BITS = NUM_PAGES - (NWORDS - 1) * WORD_BITS;
   localparam int CMP_W     = ((PAGE_W + 1) > COUNT_W) ? (PAGE_W + 1) : COUNT_W;
   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NWORDS - 1);

   // Sequencer and datapath registers.
   state_type              state_ff, state_in;
   logic [WADDR_W-1:0]     clr_ptr_ff, clr_ptr_in;
   mode_type               mode_ff, mode_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     need_ff, need_in;
   logic [WADDR_W-1:0]     eval_word_ff, eval_word_in;
   logic [PAGE_W-1:0]      page_base_ff, page_base_in;
   logic [PAGE_W-1:0]      end_page_ff, end_page_in;
   logic [WADDR_W-1:0]     mark_word_ff, mark_word_in;
   logic [BIT_W-1:0]       hi_ff, hi_in;
   logic [COUNT_W-1:0]     remain_ff, remain_in;
   logic [PAGE_W-1:0]      start_ff, start_in;
   logic [ADDR_W-1:0]      off_ff, off_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   res_ok_ff, res_ok_in;
   status_type             res_status_ff, res_status_in;
   logic                   res_pfree_ff, res_pfree_in;
   logic [BASE_W:0]        base_rnd_ff, base_rnd_in;
   logic [SHIFT_W-1:0]     page_shift_ff, page_shift_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [IDX_W-1:0]       rsp_start_ff, rsp_start_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic                   rsp_pfree_ff, rsp_pfree_in;

   // Bitmap memory.
   logic [WORD_BITS-1:0]   bitmap_mem [NWORDS];
   logic [WORD_BITS-1:0]   rdata_ff;
   logic                   mem_we;
   logic [WADDR_W-1:0]     mem_waddr;
   logic [WADDR_W-1:0]     mem_raddr;
   logic [WORD_BITS-1:0]   mem_wdata;

   // Combinational helpers.
   logic                   req_fire;
   logic                   count_zero;
   logic                   count_ok;
   logic                   idx_ok;
   logic                   last_word;
   logic [WORD_BITS-1:0]   used_vec;
   logic [LEN_W-1:0]       len_st  [STEPS+1][WORD_BITS];
   logic [WORD_BITS-1:0]   full_st [STEPS+1];
   logic [WORD_BITS-1:0]   hit_vec;
   logic                   any_hit;
   logic [BIT_W-1:0]       hit_bit;
   logic [BIT_W-1:0]       mark_lo;
   logic [BIT_W:0]         mark_cnt;
   logic [WORD_BITS-1:0]   mark_mask;
   logic [COUNT_W-1:0]     remain_next;
   logic [WADDR_W-1:0]     page_word;
   logic [BIT_W-1:0]       page_bit;
   logic [WORD_BITS-1:0]   page_mask;
   logic                   rsp_load;

   assign req_fire   = req_if.valid && req_if.ready;
   assign count_zero = (req_if.count == '0);
   assign count_ok   = (CMP_W'(req_if.count) <= CMP_W'(NUM_PAGES));
   assign idx_ok     = (CMP_W'(req_if.page_index) < CMP_W'(NUM_PAGES));
   assign last_word  = (eval_word_ff == LAST_WORD);
   assign page_word  = WADDR_W'(idx_ff >> BIT_W);
   assign page_bit   = idx_ff[BIT_W-1:0];
   assign page_mask  = WORD_BITS'(1) << page_bit;

   // Free-run lengths ending at every bit of the word under scan, built by a
   // doubling prefix network. A bit whose full flag survives is free all the way
   // back to the start of the word, so its run continues the one carried in.
   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         used_vec[j] = rdata_ff[j]
                       || (last_word && (j >= LAST_BITS))
                       || ((count_ff == COUNT_W'(1)) && (eval_word_ff == '0) && (j == 0));
         full_st[0][j] = !used_vec[j];
         len_st[0][j]  = used_vec[j] ? '0 : LEN_W'(1);
      end
      for (int k = 0; k < STEPS; k++) begin
         for (int j = 0; j < WORD_BITS; j++) begin
            if (j >= (1 << k)) begin
               full_st[k+1][j] = full_st[k][j] && full_st[k][j - (1 << k)];
               len_st[k+1][j]  = full_st[k][j] ?
                                 LEN_W'(1 << k) + len_st[k][j - (1 << k)] : len_st[k][j];
            end else begin
               full_st[k+1][j] = full_st[k][j];
               len_st[k+1][j]  = len_st[k][j];
            end
         end
      end
      for (int j = 0; j < WORD_BITS; j++) begin
         hit_vec[j] = full_st[STEPS][j] ? (COUNT_W'(j + 1) >= need_ff)
                                        : (COUNT_W'(len_st[STEPS][j]) >= count_ff);
      end
      any_hit = |hit_vec;
      hit_bit = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (hit_vec[j]) begin
            hit_bit = BIT_W'(j);
         end
      end
   end

   // Marking runs backwards from the last page of the run, one word per pass.
   always_comb begin
      if (remain_ff > COUNT_W'(hi_ff)) begin
         mark_lo = '0;
      end else begin
         mark_lo = hi_ff + BIT_W'(1) - BIT_W'(remain_ff);
      end
      mark_cnt    = (BIT_W + 1)'(hi_ff) - (BIT_W + 1)'(mark_lo) + (BIT_W + 1)'(1);
      remain_next = remain_ff - COUNT_W'(mark_cnt);
      for (int b = 0; b < WORD_BITS; b++) begin
         mark_mask[b] = (BIT_W'(b) >= mark_lo) && (BIT_W'(b) <= hi_ff);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ptr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (mode_type'(req_if.mode) == MODE_ALLOC) begin
                  state_in = (count_zero || !count_ok) ? ST_RESP : ST_SCAN_START;
               end else begin
                  state_in = idx_ok ? ST_PAGE_RD : ST_RESP;
               end
            end
         end
         ST_SCAN_START: state_in = ST_SCAN;
         ST_SCAN: begin
            if (any_hit) begin
               state_in = ST_MARK_RD;
            end else if (last_word) begin
               state_in = ST_RESP;
            end
         end
         ST_MARK_RD: state_in = ST_MARK_WR;
         ST_MARK_WR: state_in = (remain_next == '0) ? ST_RESP : ST_MARK_RD;
         ST_PAGE_RD: state_in = ST_PAGE_OP;
         ST_PAGE_OP: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and memory port control.
   always_comb begin
      req_if.ready = 1'b0;
      rsp_load     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_raddr    = '0;
      mem_wdata    = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ptr_ff;
         end
         ST_IDLE: req_if.ready = 1'b1;
         ST_SCAN_START: mem_raddr = '0;
         ST_SCAN: mem_raddr = last_word ? eval_word_ff : eval_word_ff + WADDR_W'(1);
         ST_MARK_RD: mem_raddr = mark_word_ff;
         ST_MARK_WR: begin
            mem_we    = 1'b1;
            mem_waddr = mark_word_ff;
            mem_wdata = rdata_ff | mark_mask;
         end
         ST_PAGE_RD: mem_raddr = page_word;
         ST_PAGE_OP: begin
            mem_waddr = page_word;
            unique case (mode_ff)
               MODE_MARK_USED: begin
                  mem_we    = 1'b1;
                  mem_wdata = rdata_ff | page_mask;
               end
               MODE_MARK_FREE: begin
                  mem_we    = 1'b1;
                  mem_wdata = rdata_ff & ~page_mask;
               end
               default: mem_we = 1'b0;
            endcase
         end
         ST_RESP: rsp_load = !rsp_valid_ff || rsp_if.ready;
         default: req_if.ready = 1'b0;
      endcase
   end

   // Datapath next values.
   always_comb begin
      clr_ptr_in    = clr_ptr_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      need_in       = need_ff;
      eval_word_in  = eval_word_ff;
      page_base_in  = page_base_ff;
      end_page_in   = end_page_ff;
      mark_word_in  = mark_word_ff;
      hi_in         = hi_ff;
      remain_in     = remain_ff;
      start_in      = start_ff;
      off_in        = off_ff;
      idx_in        = idx_ff;
      res_ok_in     = res_ok_ff;
      res_status_in = res_status_ff;
      res_pfree_in  = res_pfree_ff;
      base_rnd_in   = base_rnd_ff;
      page_shift_in = page_shift_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_FREE_BASE:  base_rnd_in = ({1'b0, csr_wdata} + BASE_ROUND) & ~BASE_ROUND;
            CSR_PAGE_SHIFT: page_shift_in = csr_wdata[SHIFT_W-1:0];
            default:        page_shift_in = page_shift_ff;
         endcase
      end

      case (state_ff)
         ST_CLEAR: clr_ptr_in = clr_ptr_ff + WADDR_W'(1);
         ST_IDLE: begin
            if (req_fire) begin
               mode_in      = mode_type'(req_if.mode);
               count_in     = req_if.count;
               need_in      = req_if.count;
               idx_in       = req_if.page_index;
               start_in     = '0;
               res_ok_in    = 1'b0;
               res_pfree_in = 1'b0;
               if (mode_type'(req_if.mode) == MODE_ALLOC && count_zero) begin
                  res_status_in = STATUS_ZERO_COUNT;
               end else if (mode_type'(req_if.mode) == MODE_ALLOC && !count_ok) begin
                  res_status_in = STATUS_NO_RUN;
               end else begin
                  res_status_in = STATUS_OK;
               end
            end
         end
         ST_SCAN_START: begin
            eval_word_in = '0;
            page_base_in = '0;
         end
         ST_SCAN: begin
            if (any_hit) begin
               mark_word_in = eval_word_ff;
               hi_in        = hit_bit;
               remain_in    = count_ff;
               end_page_in  = page_base_ff + PAGE_W'(hit_bit);
               res_ok_in    = 1'b1;
            end else if (last_word) begin
               res_status_in = STATUS_NO_RUN;
            end else begin
               eval_word_in = eval_word_ff + WADDR_W'(1);
               page_base_in = page_base_ff + PAGE_W'(WORD_BITS);
               need_in      = full_st[STEPS][WORD_BITS-1] ?
                              need_ff - COUNT_W'(WORD_BITS) :
                              count_ff - COUNT_W'(len_st[STEPS][WORD_BITS-1]);
            end
         end
         ST_MARK_RD: start_in = end_page_ff - PAGE_W'(count_ff) + PAGE_W'(1);
         ST_MARK_WR: begin
            off_in       = ADDR_W'(start_ff) << page_shift_ff;
            remain_in    = remain_next;
            mark_word_in = mark_word_ff - WADDR_W'(1);
            hi_in        = BIT_W'(WORD_BITS - 1);
         end
         ST_PAGE_OP: begin
            if (mode_ff == MODE_QUERY) begin
               res_pfree_in = !rdata_ff[page_bit];
            end
         end
         default: clr_ptr_in = clr_ptr_ff;
      endcase
   end

   // Response register, loaded when the previous response has gone.
   always_comb begin
      rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_if.ready);
      rsp_addr_in   = rsp_addr_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pfree_in  = rsp_pfree_ff;
      if (rsp_load) begin
         rsp_addr_in   = res_ok_ff ? ADDR_W'(base_rnd_ff) + off_ff : '0;
         rsp_start_in  = IDX_W'(start_ff);
         rsp_status_in = res_status_ff;
         rsp_pfree_in  = res_pfree_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ptr_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         base_rnd_ff   <= '0;
         page_shift_ff <= PAGE_SHIFT_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ptr_ff    <= clr_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
         base_rnd_ff   <= base_rnd_in;
         page_shift_ff <= page_shift_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      count_ff      <= count_in;
      need_ff       <= need_in;
      eval_word_ff  <= eval_word_in;
      page_base_ff  <= page_base_in;
      end_page_ff   <= end_page_in;
      mark_word_ff  <= mark_word_in;
      hi_ff         <= hi_in;
      remain_ff     <= remain_in;
      start_ff      <= start_in;
      off_ff        <= off_in;
      idx_ff        <= idx_in;
      res_ok_ff     <= res_ok_in;
      res_status_ff <= res_status_in;
      res_pfree_ff  <= res_pfree_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pfree_ff  <= rsp_pfree_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= bitmap_mem[mem_raddr];
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.phys_address = rsp_addr_ff;
   assign rsp_if.run_start    = rsp_start_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.page_free    = rsp_pfree_ff;

endmodule
